>>> rtl/core/sitd_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
`default_nettype none

package sitd_pkg;

   // Field widths.
   localparam int VALUE_W  = 32;
   localparam int CHAR_W   = 6;
   localparam int DIGIT_W  = 4;

   // A 32-bit magnitude has at most ten decimal digits.
   localparam int MAX_DIGITS = 10;
   localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);

   // Character codes.
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

   // Divide by ten through a reciprocal: q = (x * RECIP_TEN) >> RECIP_SHIFT,
   // exact for every 32-bit x.
   localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                 RECIP_SHIFT = 35;
   localparam int                 QUOT_W      = 2 * VALUE_W - RECIP_SHIFT;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_REM,
      ST_SIGN,
      ST_DIGIT
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/sitd_req_if.sv
// Request channel: one signed integer per request.
`default_nettype none

interface sitd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sitd_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sitd_rsp_if.sv
// Response channel: one ASCII character per response, with a last flag.
`default_nettype none

interface sitd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sitd_pkg::CHAR_W-1:0]  char_code;
   logic                         last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sitd_div10.sv
// Registered divide-by-ten unit: quotient and remainder appear in the cycle after the operand.
`default_nettype none

module sitd_div10 (
   input  wire logic                          clock,
   input  wire logic [sitd_pkg::VALUE_W-1:0]  dividend,
   output logic      [sitd_pkg::VALUE_W-1:0]  quotient,
   output logic      [sitd_pkg::DIGIT_W-1:0]  remainder
);
   import sitd_pkg::*;

   logic [2*VALUE_W-1:0] product;
   logic [QUOT_W-1:0]    quotient_ff;
   logic [QUOT_W-1:0]    quotient_in;
   logic [VALUE_W-1:0]   dividend_ff;
   logic [VALUE_W-1:0]   times_ten;
   logic [VALUE_W-1:0]   difference;

   // Multiply by the scaled reciprocal and keep the high bits as the quotient.
   assign product     = (2*VALUE_W)'(dividend) * (2*VALUE_W)'(RECIP_TEN);
   assign quotient_in = product[2*VALUE_W-1:RECIP_SHIFT];

   always_ff @(posedge clock) begin
      quotient_ff <= quotient_in;
      dividend_ff <= dividend;
   end

   // The remainder is what is left after subtracting ten times the quotient.
   assign quotient   = VALUE_W'(quotient_ff);
   assign times_ten  = (quotient << 3) + (quotient << 1);
   assign difference = dividend_ff - times_ten;
   assign remainder  = difference[DIGIT_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/signed_int_to_decimal_ascii.sv
// Top level: converts a signed 32-bit integer into its decimal ASCII text.
//
//   Channel   Direction   Payload                  Per request
//   req_ch    in          value (signed 32 bits)   one integer
//   rsp_ch    out         char_code, last_char     1 to 11 characters
//
// A value of n digits is accepted in idle, then each digit takes a divide step
// in the divide-by-ten unit (ST_DIV to multiply, then ST_REM for the remainder),
// and then the characters are sent, a minus sign first for a negative value.
// Reset is synchronous and returns the sequencer to idle with nothing pending.
// A stalled response holds its character; no new request is taken until the
// last character of the current value has been delivered.
`default_nettype none

module signed_int_to_decimal_ascii (
   input  wire logic    clock,
   input  wire logic    reset,
   sitd_req_if.sink     req_ch,
   sitd_rsp_if.source   rsp_ch
);
   import sitd_pkg::*;

   state_type            state_ff;
   state_type            state_in;
   logic [VALUE_W-1:0]   mag_ff;
   logic [VALUE_W-1:0]   mag_in;
   logic                 neg_ff;
   logic                 neg_in;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;
   logic [COUNT_W-1:0]   idx_ff;
   logic [COUNT_W-1:0]   idx_in;
   logic [DIGIT_W-1:0]   digits_ff [MAX_DIGITS];

   logic [VALUE_W-1:0]   quotient;
   logic [DIGIT_W-1:0]   remainder;
   logic [VALUE_W-1:0]   raw_value;
   logic                 req_fire;
   logic                 rsp_fire;

   assign raw_value = VALUE_W'(req_ch.value);
   assign req_fire  = req_ch.valid && req_ch.ready;
   assign rsp_fire  = rsp_ch.valid && rsp_ch.ready;

   // Shared divide-by-ten unit, always working on the current magnitude.
   sitd_div10 u_div10 (
      .clock     (clock),
      .dividend  (mag_ff),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // Sequencer state and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         neg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         neg_ff   <= neg_in;
      end
   end

   // Magnitude and digit store.
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      if (state_ff == ST_REM) begin
         digits_ff[count_ff] <= remainder;
      end
   end

   // Next state and channel outputs.
   always_comb begin
      state_in         = state_ff;
      mag_in           = mag_ff;
      neg_in           = neg_ff;
      count_in         = count_ff;
      idx_in           = idx_ff;
      req_ch.ready     = 1'b0;
      rsp_ch.valid     = 1'b0;
      rsp_ch.char_code = CHAR_ZERO + CHAR_W'(digits_ff[idx_ff]);
      rsp_ch.last_char = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_fire) begin
               neg_in   = raw_value[VALUE_W-1];
               mag_in   = raw_value[VALUE_W-1] ? ('0 - raw_value) : raw_value;
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // The divide unit captures the magnitude this cycle.
            state_in = ST_REM;
         end
         ST_REM: begin
            mag_in   = quotient;
            count_in = count_ff + 1'b1;
            if (quotient == '0 || count_in == COUNT_W'(MAX_DIGITS)) begin
               idx_in   = count_ff;
               state_in = neg_ff ? ST_SIGN : ST_DIGIT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_SIGN: begin
            rsp_ch.valid     = 1'b1;
            rsp_ch.char_code = CHAR_MINUS;
            if (rsp_fire) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            // Digits were stored least significant first; send them back down.
            rsp_ch.valid     = 1'b1;
            rsp_ch.last_char = (idx_ff == '0);
            if (rsp_fire) begin
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // An accepted request always starts a divide step.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_DIV)
      else $error("accepted request did not start conversion");

   // The divide unit only ever produces a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REM |-> remainder < DIGIT_W'(10))
      else $error("divide unit remainder out of range");

   // A minus sign is only sent for a negative value.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIGN |-> neg_ff)
      else $error("minus sign for a non-negative value");

   // Delivering the last character returns the block to idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_ch.last_char) |=> state_ff == ST_IDLE)
      else $error("block not idle after last character");
`endif

endmodule

`default_nettype wire
